### src/multichannel_decimating_averager_macros.svh
// Assertion macros for the multichannel decimating averager.
`ifndef MULTICHANNEL_DECIMATING_AVERAGER_MACROS_SVH
`define MULTICHANNEL_DECIMATING_AVERAGER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MDA_CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MDA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mda_pkg.sv
// Shared types and constants of the multichannel decimating averager.
package mda_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int RAW_W      = 32;
  localparam int CHAN_W     = 2;
  localparam int IDX_W      = 16;
  localparam int COOKED_W   = 48;
  localparam int DECIM_W    = 11;
  localparam int FRAME_W    = 17;
  localparam int LANE_W     = 16;
  localparam int FRAC_BITS  = 12;
  localparam int QUEUE_DEPTH = 4;

  // Largest decimation the 11-bit register can express
  localparam int DECIM_REG_MAX = 2047;
  localparam int FRAME_MAX     = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIMATION   = 2'd0,
    REG_SAMPLES_PER_FRAME = 2'd1,
    REG_SCALE_TABLE  = 2'd2,
    REG_OFFSET_TABLE = 2'd3
  } reg_idx_t;

  localparam logic [DECIM_W-1:0]    DECIM_RST  = 11'd1;
  localparam logic [FRAME_W-1:0]    FRAME_RST  = 17'd100;
  localparam logic [CFG_DATA_W-1:0] SCALE_RST  = 64'h1000_1000_1000_1000;
  localparam logic [CFG_DATA_W-1:0] OFFSET_RST = 64'h0;

  localparam logic signed [COOKED_W-1:0] COOKED_MAX = {1'b0, {(COOKED_W-1){1'b1}}};
  localparam logic signed [COOKED_W-1:0] COOKED_MIN = {1'b1, {(COOKED_W-1){1'b0}}};

  // Effective configuration seen by front and back
  typedef struct packed {
    logic [DECIM_W-1:0]    eff_d;
    logic [FRAME_W-1:0]    eff_f;
    logic [CFG_DATA_W-1:0] scale;
    logic [CFG_DATA_W-1:0] offset;
  } cfg_t;

endpackage

### src/mda_ifs.sv
// Stream interfaces for raw sample words and cooked result words.
interface mda_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface mda_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel;
  logic [15:0]        sample_index;
  logic signed [47:0] cooked_value;
  logic               frame_end;

  modport source (output valid, output channel, output sample_index,
                  output cooked_value, output frame_end, input ready);
  modport sink   (input valid, input channel, input sample_index,
                  input cooked_value, input frame_end, output ready);
endinterface

### src/mda_fifo.sv
// Small show-ahead job queue between the front and the back.
module mda_fifo #(
  parameter int W     = 61,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

### src/mda_front.sv
// Front end: accepts raw words, accumulates per channel, queues finished runs.
module mda_front #(
  parameter int NUM_CHANNELS = 4,
  parameter int DW           = 10,
  parameter int SUM_W        = 42,
  parameter int JW           = 61
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mda_pkg::cfg_t   cfg,
  mda_in_if.sink          in_word,
  output logic            push_valid,
  input  logic            push_ready,
  output logic [JW-1:0]   push_data
);
  import mda_pkg::*;

  localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic signed [SUM_W-1:0] sums_r [NUM_CHANNELS];
  logic [CHAN_W-1:0]       ch_r;
  logic [DW-1:0]           decim_r;
  logic [IDX_W-1:0]        samp_r;

  logic                    accept, last_tp, last_ch, last_sample, frame_end;
  logic [CIW-1:0]          ch_idx;
  logic signed [SUM_W-1:0] new_sum;

  assign in_word.ready = push_ready;
  assign accept        = in_word.valid && in_word.ready;
  assign ch_idx        = ch_r[CIW-1:0];
  assign new_sum       = sums_r[ch_idx] + SUM_W'(in_word.raw_sample);

  // Classify the word: end of run, end of time point, end of frame
  assign last_tp     = (12'(decim_r) + 12'd1) >= {1'b0, cfg.eff_d};
  assign last_ch     = (ch_r == CHAN_W'(NUM_CHANNELS - 1));
  assign last_sample = (17'(samp_r) + 17'd1) >= cfg.eff_f;
  assign frame_end   = last_ch && last_sample;

  assign push_valid = accept && last_tp;
  assign push_data  = {ch_r, samp_r, frame_end, new_sum};

  // Accumulate, and clear a channel once its run is queued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums_r[i] <= '0;
      end
    end else if (accept) begin
      sums_r[ch_idx] <= last_tp ? '0 : new_sum;
    end
  end

  // Advance channel, decimation and sample counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r    <= '0;
      decim_r <= '0;
      samp_r  <= '0;
    end else if (accept) begin
      if (last_ch) begin
        ch_r <= '0;
        if (last_tp) begin
          decim_r <= '0;
          samp_r  <= last_sample ? '0 : samp_r + 1'b1;
        end else begin
          decim_r <= decim_r + 1'b1;
        end
      end else begin
        ch_r <= ch_r + 1'b1;
      end
    end
  end
endmodule

### src/mda_back.sv
// Back end: scales, averages by iterative division, offsets and saturates.
module mda_back #(
  parameter int SUM_W = 42,
  parameter int JW    = 61
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mda_pkg::cfg_t cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  logic [JW-1:0] pop_data,
  mda_out_if.source     out_word
);
  import mda_pkg::*;

  localparam int P_W = SUM_W + LANE_W;   // product width
  localparam int NW  = P_W + 1;          // dividend width after rounding bias
  localparam int VW  = NW + 2;           // cooked value before saturation
  localparam int CW  = $clog2(NW);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_PREP = 5'b00100,
    B_DIV  = 5'b01000,
    B_FIN  = 5'b10000
  } bstate_t;

  bstate_t                 state_r, state_nxt;
  logic [CHAN_W-1:0]       ch_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    fe_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [P_W-1:0]   prod_r;
  logic                    neg_r;
  logic [NW-1:0]           div_r;
  logic [DECIM_W-1:0]      rem_r;
  logic [CW-1:0]           cnt_r;

  logic                    out_valid_r;
  logic [CHAN_W-1:0]       out_ch_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [COOKED_W-1:0] out_val_r;
  logic                    out_fe_r;

  logic                    slot_free;
  logic signed [LANE_W-1:0] scale_s, offset_s;
  logic signed [NW-1:0]    prod_ext;
  logic [NW-1:0]           half_ext, biased;
  logic [DECIM_W:0]        trial;
  logic                    ge;
  logic signed [VW-1:0]    off_ext, q_ext, val;
  logic signed [COOKED_W-1:0] sat;

  assign slot_free = !out_valid_r || out_word.ready;
  assign pop_ready = (state_r == B_IDLE);

  assign scale_s  = $signed(cfg.scale[{ch_r, 4'b0000} +: LANE_W]);
  assign offset_s = $signed(cfg.offset[{ch_r, 4'b0000} +: LANE_W]);

  // Magnitude plus half divisor, folded into one add
  assign prod_ext = NW'(prod_r);
  assign half_ext = NW'(cfg.eff_d[DECIM_W-1:1]);
  assign biased   = prod_r[P_W-1] ? (half_ext - prod_ext) : (NW'(prod_ext) + half_ext);

  // One restoring division step
  assign trial = {rem_r, div_r[NW-1]};
  assign ge    = trial >= {1'b0, cfg.eff_d};

  // Apply sign and offset, then clamp to the output range
  assign off_ext = VW'(offset_s) <<< FRAC_BITS;
  assign q_ext   = $signed(VW'(div_r));
  assign val     = neg_r ? (off_ext - q_ext) : (off_ext + q_ext);
  always_comb begin
    if (val[VW-1:COOKED_W-1] == '0 || val[VW-1:COOKED_W-1] == '1) begin
      sat = val[COOKED_W-1:0];
    end else begin
      sat = val[VW-1] ? COOKED_MIN : COOKED_MAX;
    end
  end

  // Sequence one job through multiply, bias, divide and output
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (pop_valid) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_PREP;
      B_PREP: state_nxt = B_DIV;
      B_DIV:  if (cnt_r == '0) state_nxt = B_FIN;
      B_FIN:  if (slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          {ch_r, idx_r, fe_r, sum_r} <= pop_data;
        end
      end
      B_MUL: begin
        prod_r <= sum_r * scale_s;
      end
      B_PREP: begin
        neg_r <= prod_r[P_W-1];
        div_r <= biased;
        rem_r <= '0;
        cnt_r <= CW'(NW - 1);
      end
      B_DIV: begin
        rem_r <= ge ? DECIM_W'(trial - {1'b0, cfg.eff_d}) : trial[DECIM_W-1:0];
        div_r <= {div_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_FIN && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_FIN && slot_free) begin
      out_ch_r  <= ch_r;
      out_idx_r <= idx_r;
      out_val_r <= sat;
      out_fe_r  <= fe_r;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.channel      = out_ch_r;
  assign out_word.sample_index = out_idx_r;
  assign out_word.cooked_value = out_val_r;
  assign out_word.frame_end    = out_fe_r;
endmodule

### src/multichannel_decimating_averager.sv
// Top level of the multichannel decimating averager.
//
//   port      | dir | carries
//   ----------+-----+-----------------------------------------------
//   in_word   | in  | raw_sample, one word per channel per time point
//   out_word  | out | channel, sample_index, cooked_value, frame_end
//   cfg_*     | in  | register writes: index, 64-bit data
//
// The front takes one raw word per cycle while the job queue has room.
// The back works one finished run at a time and takes no new job until it is
// done: one load, one multiply, one bias add, SUM_W + 17 restoring division
// steps of one bit each, and one offset/saturate step that waits for the output slot.
// With a small decimation d the back falls behind; the queue then fills and
// ready drops. Reset clears sums, counters, queue.
module multichannel_decimating_averager #(
  parameter int NUM_CHANNELS   = 4,
  parameter int MAX_DECIMATION = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mda_in_if.sink                         in_word,
  mda_out_if.source                      out_word,
  input  logic                           cfg_we,
  input  logic [mda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mda_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mda_pkg::*;

  localparam int EFF_MAX = (MAX_DECIMATION < DECIM_REG_MAX) ? MAX_DECIMATION : DECIM_REG_MAX;
  localparam int DW      = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
  localparam int SUM_W   = RAW_W + DW;
  localparam int JW      = CHAN_W + IDX_W + 1 + SUM_W;

  logic [DECIM_W-1:0]    decimation_r;
  logic [FRAME_W-1:0]    frame_r;
  logic [CFG_DATA_W-1:0] scale_r, offset_r;
  cfg_t                  cfg;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  logic [JW-1:0]         push_data, pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimation_r <= DECIM_RST;
      frame_r      <= FRAME_RST;
      scale_r      <= SCALE_RST;
      offset_r     <= OFFSET_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DECIMATION:        decimation_r <= cfg_data[DECIM_W-1:0];
        REG_SAMPLES_PER_FRAME: frame_r      <= cfg_data[FRAME_W-1:0];
        REG_SCALE_TABLE:       scale_r      <= cfg_data;
        REG_OFFSET_TABLE:      offset_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamp decimation and frame length to their legal ranges
  always_comb begin
    if (decimation_r == '0) begin
      cfg.eff_d = DECIM_W'(1);
    end else if (17'(decimation_r) > 17'(EFF_MAX)) begin
      cfg.eff_d = DECIM_W'(EFF_MAX);
    end else begin
      cfg.eff_d = decimation_r;
    end
    if (frame_r == '0) begin
      cfg.eff_f = FRAME_W'(1);
    end else if (frame_r > FRAME_W'(FRAME_MAX)) begin
      cfg.eff_f = FRAME_W'(FRAME_MAX);
    end else begin
      cfg.eff_f = frame_r;
    end
    cfg.scale  = scale_r;
    cfg.offset = offset_r;
  end

  mda_front #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .DW          (DW),
    .SUM_W       (SUM_W),
    .JW          (JW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_word   (in_word),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  mda_fifo #(
    .W    (JW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  mda_back #(
    .SUM_W(SUM_W),
    .JW   (JW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_word (out_word)
  );

  // Checks
  `include "multichannel_decimating_averager_macros.svh"

  `MDA_CHK_IMPLY(a_frame_end_last_ch, out_word.valid && out_word.frame_end, out_word.channel == CHAN_W'(NUM_CHANNELS - 1), "frame end on a channel other than the last")
  `MDA_CHK_IMPLY(a_push_has_room, push_valid, push_ready, "job pushed into a full queue")
  `MDA_CHK_NEXT(a_pop_starts_job, pop_valid && pop_ready, !pop_ready, "back end took a second job without working the first")
endmodule

### test/tb_multichannel_decimating_averager.sv
// Self-checking testbench for the multichannel decimating averager.
module tb_multichannel_decimating_averager;
  import mda_pkg::*;

  localparam int NUM_CH        = 4;
  localparam int MAX_DECIM     = 1024;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 850;
  localparam int QUIET_ITEMS   = 400;
  localparam int LONG_RUN_TPS  = 200;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic [CHAN_W-1:0]          channel;
    logic [IDX_W-1:0]           sample_index;
    logic signed [COOKED_W-1:0] cooked_value;
    logic                       frame_end;
  } cooked_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mda_in_if  in_word_if();
  mda_out_if out_word_if();

  multichannel_decimating_averager #(
    .NUM_CHANNELS  (NUM_CH),
    .MAX_DECIMATION(MAX_DECIM)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word_if),
    .out_word (out_word_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Register shadows and predictor state
  logic [DECIM_W-1:0]    decim_reg;
  logic [FRAME_W-1:0]    frame_reg;
  logic [CFG_DATA_W-1:0] scale_reg;
  logic [CFG_DATA_W-1:0] offset_reg;
  longint                acc_sums [NUM_CH];
  int unsigned           chan_cnt;
  int unsigned           decim_cnt;
  int unsigned           sample_cnt;

  cooked_word_t expected_words [$];
  cooked_word_t head_word;

  bit          idle_en;
  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned cycle_count;

  always #5 clk = ~clk;

  // Scale one channel sum to a cooked value: round half away from zero, saturate
  function automatic logic signed [COOKED_W-1:0] cook_sum(longint acc, int unsigned c,
                                                          int unsigned d);
    longint          prod;
    longint          avg;
    longint          v;
    longint unsigned mag;
    longint unsigned q;
    bit              neg;
    prod = acc * longint'($signed(scale_reg[LANE_W*c +: LANE_W]));
    neg  = prod < 0;
    mag  = neg ? -prod : prod;
    q    = (mag + d / 2) / d;
    avg  = neg ? -longint'(q) : longint'(q);
    v    = avg + longint'($signed(offset_reg[LANE_W*c +: LANE_W])) * 4096;
    if (v > longint'(COOKED_MAX)) v = longint'(COOKED_MAX);
    if (v < longint'(COOKED_MIN)) v = longint'(COOKED_MIN);
    return v[COOKED_W-1:0];
  endfunction

  // Accumulate one raw word and queue the cooked word it completes, if any
  function automatic void predict_cooked(logic signed [RAW_W-1:0] raw);
    int unsigned  d;
    int unsigned  f;
    int unsigned  c;
    bit           last_tp;
    bit           last_ch;
    bit           last_smp;
    cooked_word_t w;
    d = (decim_reg == 0) ? 1 : (decim_reg > MAX_DECIM) ? MAX_DECIM : int'(decim_reg);
    f = (frame_reg == 0) ? 1 : (frame_reg > FRAME_MAX) ? FRAME_MAX : int'(frame_reg);
    c = chan_cnt;
    acc_sums[c] += longint'(raw);
    last_tp  = decim_cnt + 1 >= d;
    last_ch  = c + 1 >= NUM_CH;
    last_smp = sample_cnt + 1 >= f;
    if (last_tp) begin
      w.channel      = c[CHAN_W-1:0];
      w.sample_index = sample_cnt[IDX_W-1:0];
      w.cooked_value = cook_sum(acc_sums[c], c, d);
      w.frame_end    = last_ch && last_smp;
      expected_words.push_back(w);
      acc_sums[c] = 0;
    end
    if (last_ch) begin
      chan_cnt = 0;
      if (last_tp) begin
        decim_cnt  = 0;
        sample_cnt = last_smp ? 0 : (sample_cnt + 1) & 16'hFFFF;
      end else begin
        decim_cnt = (decim_cnt + 1) & 10'h3FF;
      end
    end else begin
      chan_cnt = c + 1;
    end
  endfunction

  function automatic bit idle_roll();
    return idle_en && ($urandom_range(99) < 35);
  endfunction

  // Send one raw word; predict at the accepting edge
  task automatic push_raw(logic signed [RAW_W-1:0] raw);
    @(negedge clk);
    while (idle_roll()) begin
      in_word_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_word_if.valid      <= 1'b1;
    in_word_if.raw_sample <= raw;
    do @(posedge clk); while (!in_word_if.ready);
    predict_cooked(raw);
    items_sent++;
  endtask

  // Hold the input and wait until every expected word has come out
  task automatic settle_block();
    @(negedge clk);
    in_word_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DECIMATION:        decim_reg  = val[DECIM_W-1:0];
      REG_SAMPLES_PER_FRAME: frame_reg  = val[FRAME_W-1:0];
      REG_SCALE_TABLE:       scale_reg  = val;
      REG_OFFSET_TABLE:      offset_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [RAW_W-1:0] rand_raw();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'sh7FFF_FFFF;
    if (r < 20) return 32'sh8000_0000;
    if (r < 30) return $signed($urandom_range(31)) - 16;
    return $urandom;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_lanes();
    logic [CFG_DATA_W-1:0] t;
    int unsigned           r;
    for (int c = 0; c < NUM_CH; c++) begin
      r = $urandom_range(99);
      if (r < 15)      t[LANE_W*c +: LANE_W] = 16'h7FFF;
      else if (r < 30) t[LANE_W*c +: LANE_W] = 16'h8000;
      else if (r < 40) t[LANE_W*c +: LANE_W] = 16'h0000;
      else if (r < 50) t[LANE_W*c +: LANE_W] = 16'h1000;
      else             t[LANE_W*c +: LANE_W] = $urandom_range(16'hFFFF);
    end
    return t;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_decimation();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 10) return $urandom_range(DECIM_REG_MAX, MAX_DECIM);
    if (r < 20) return $urandom_range(40, 9);
    return $urandom_range(8, 1);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_frame();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 10) return $urandom_range(131071, FRAME_MAX);
    if (r < 15) return $urandom_range(65535, 7);
    return $urandom_range(6, 1);
  endfunction

  // Full-scale words at the reset settings
  task automatic test_default_settings();
    push_raw(32'sh7FFF_FFFF);
    push_raw(32'sh8000_0000);
    push_raw(32'sh0000_0000);
    push_raw(-32'sd1);
  endtask

  // Build large sums at the clamped decimation, then shrink it to force saturation
  task automatic test_saturation();
    settle_block();
    write_reg(REG_SCALE_TABLE, {16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
    write_reg(REG_OFFSET_TABLE, {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});
    write_reg(REG_DECIMATION, DECIM_REG_MAX);
    repeat (4) begin
      push_raw(32'sh7FFF_FFFF);
      push_raw(32'sh8000_0000);
      push_raw(32'sh7FFF_FFFF);
      push_raw(32'sh8000_0000);
    end
    settle_block();
    write_reg(REG_DECIMATION, 1);
    push_raw(32'sh7FFF_FFFF);
    push_raw(32'sh8000_0000);
    push_raw(32'sh7FFF_FFFF);
    push_raw(32'sh8000_0000);
  endtask

  // Zero decimation and zero frame length both act as one
  task automatic test_zero_settings();
    settle_block();
    write_reg(REG_DECIMATION, 0);
    write_reg(REG_SAMPLES_PER_FRAME, 0);
    repeat (NUM_CH) push_raw(rand_raw());
    settle_block();
    write_reg(REG_SAMPLES_PER_FRAME, 131071);
  endtask

  // Exact halves round away from zero on both signs
  task automatic test_rounding();
    settle_block();
    write_reg(REG_SCALE_TABLE, {16'h8001, 16'h0003, 16'hFFFF, 16'h0001});
    write_reg(REG_OFFSET_TABLE, {16'h0002, 16'hFFFE, 16'h0001, 16'hFFFF});
    write_reg(REG_DECIMATION, 2);
    push_raw(1);
    push_raw(1);
    push_raw(-1);
    push_raw(1);
    push_raw(2);
    push_raw(0);
    push_raw(-2);
    push_raw(0);
  endtask

  // Long run at the largest decimation with extreme sums, closed by lowering
  // the decimation so the counter reaches the new limit on the next time point
  task automatic test_max_decimation();
    settle_block();
    write_reg(REG_DECIMATION, MAX_DECIM);
    write_reg(REG_SAMPLES_PER_FRAME, 3);
    write_reg(REG_SCALE_TABLE, rand_lanes());
    write_reg(REG_OFFSET_TABLE, rand_lanes());
    repeat (LONG_RUN_TPS) begin
      push_raw(32'sh7FFF_FFFF);
      push_raw(32'sh8000_0000);
      push_raw(rand_raw());
      push_raw(rand_raw());
    end
    settle_block();
    write_reg(REG_DECIMATION, LONG_RUN_TPS + 1);
    push_raw(32'sh7FFF_FFFF);
    push_raw(32'sh8000_0000);
    push_raw(rand_raw());
    push_raw(rand_raw());
  endtask

  // Random phases: new settings between phases, counters carried over
  task automatic test_random_phases();
    int unsigned first_item;
    int unsigned n;
    first_item = items_sent;
    idle_en    = 1'b0;
    while (items_sent < first_item + RANDOM_ITEMS) begin
      if (items_sent >= first_item + QUIET_ITEMS) idle_en = 1'b1;
      settle_block();
      if ($urandom_range(9) < 6) write_reg(REG_DECIMATION, rand_decimation());
      if ($urandom_range(9) < 6) write_reg(REG_SAMPLES_PER_FRAME, rand_frame());
      if ($urandom_range(9) < 5) write_reg(REG_SCALE_TABLE, rand_lanes());
      if ($urandom_range(9) < 5) write_reg(REG_OFFSET_TABLE, rand_lanes());
      n = $urandom_range(120, 8);
      repeat (n) push_raw(rand_raw());
    end
    idle_en = 1'b1;
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    out_word_if.ready <= !idle_roll();
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_word_if.valid && out_word_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: channel %0d sample_index %0d",
               out_word_if.channel, out_word_if.sample_index);
        fail_count++;
      end else begin
        head_word = expected_words.pop_front();
        if (out_word_if.channel !== head_word.channel) begin
          $error("channel: expected %0d, actual %0d",
                 head_word.channel, out_word_if.channel);
          fail_count++;
        end
        if (out_word_if.sample_index !== head_word.sample_index) begin
          $error("sample_index: expected %0d, actual %0d",
                 head_word.sample_index, out_word_if.sample_index);
          fail_count++;
        end
        if (out_word_if.cooked_value !== head_word.cooked_value) begin
          $error("cooked_value: expected %0d, actual %0d",
                 head_word.cooked_value, out_word_if.cooked_value);
          fail_count++;
        end
        if (out_word_if.frame_end !== head_word.frame_end) begin
          $error("frame_end: expected %0d, actual %0d",
                 head_word.frame_end, out_word_if.frame_end);
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_DECIMATION;
    cfg_data              = '0;
    in_word_if.valid      = 1'b0;
    in_word_if.raw_sample = '0;
    out_word_if.ready     = 1'b0;
    idle_en               = 1'b1;
    items_sent            = 0;
    fail_count            = 0;
    cycle_count           = 0;
    decim_reg             = DECIM_RST;
    frame_reg             = FRAME_RST;
    scale_reg             = SCALE_RST;
    offset_reg            = OFFSET_RST;
    chan_cnt              = 0;
    decim_cnt             = 0;
    sample_cnt            = 0;
    for (int c = 0; c < NUM_CH; c++) acc_sums[c] = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_settings();
    test_saturation();
    test_zero_settings();
    test_rounding();
    test_max_decimation();
    test_random_phases();
    settle_block();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
